// ===== hdl/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// Script tokenizer package
// Shared constants, event and job types, and character class helpers for the
// byte-serial script lexer.
// ----------------------------------------------------------------------------
package stok_pkg;

  // Job queue between the front and back parts
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  // Room for the events that one text byte can cause, which are at most seven
  localparam int JOB_EVTS = 8;
  localparam int JIDX_W   = $clog2(JOB_EVTS);

  // Event codes
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_CHAR  = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // Token kinds
  localparam logic [1:0] KIND_QUOTED   = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_NUMBER   = 2'd2;
  localparam logic [1:0] KIND_BARE     = 2'd3;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Byte order mark length
  localparam logic [1:0] BOM_LEN = 2'd3;

  typedef struct packed {
    logic [1:0] ev;
    logic [1:0] kind;
    logic [7:0] data;
  } tok_evt_t;

  // All events caused by one text byte; last is the index of the final one.
  typedef struct packed {
    tok_evt_t [JOB_EVTS-1:0] evts;
    logic [JIDX_W-1:0]       last;
  } tok_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic tok_evt_t mk_evt(logic [1:0] ev, logic [1:0] kind, logic [7:0] data);
    tok_evt_t e;
    e.ev   = ev;
    e.kind = kind;
    e.data = data;
    return e;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == CH_EQ) || (c == CH_LBRACE) || (c == CH_RBRACE) ||
           (c == CH_GT) || (c == CH_LT) || (c == CH_COLON);
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT) || (c == CH_MINUS);
  endfunction

  // Bytes of the UTF-8 byte order mark
  function automatic logic [7:0] bom_byte(logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      2'd2:    b = 8'hBF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/script_tokenizer.sv =====
// Path: the events of an accepted byte go into a queue slot, then one at a time
// into the output register. Throughput, while the output is not stalled: one text
// byte per cycle while each byte gives at most one event; overall one event per
// cycle, set by the single output register of the back end.
// Reset: synchronous and active high; lexer state, queue and output valid clear,
// strong string mode returns to off. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Script tokenizer top level
// Byte-serial lexer for a small script language: text bytes in, token start,
// character and end events out, with a job queue between classify and emit.
// ----------------------------------------------------------------------------
module script_tokenizer (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       strong_string_mode,
  // text byte channel
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] char_byte,
  input  logic       end_of_text,
  // token event channel
  output logic       token_valid,
  input  logic       token_stall,
  output logic [1:0] event_res,
  output logic [1:0] token_kind,
  output logic [7:0] token_byte,
  output logic       run_last
);

  // The strong mode register. The user must make writes only while the block is idle;
  // the block itself does not enforce this, and the port can always take writes.
  logic strict_quotes;

  logic                accept;
  logic                push;
  logic                pop;
  stok_pkg::tok_job_t  wr_job;
  stok_pkg::tok_job_t  rd_job;
  stok_pkg::q_status_t qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_quotes <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      strict_quotes <= strong_string_mode;
    end
  end

  // A byte is taken whenever the queue has room, regardless of whether the
  // back end is stalled; every byte's events fit in one queue slot.
  assign byte_stall = qstat.full;
  assign accept     = byte_valid && !byte_stall;

  // Front end: lexer state and event list building for each beat.
  stok_front u_front (
    .clk          (clk),
    .rst          (rst),
    .strict_quotes(strict_quotes),
    .accept       (accept),
    .char_byte    (char_byte),
    .end_of_text  (end_of_text),
    .push         (push),
    .job          (wr_job)
  );

  // Jobs wait here so that a stalled output does not hold the input at once.
  stok_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_job(wr_job),
    .pop   (pop),
    .rd_job(rd_job),
    .status(qstat)
  );

  // Back end: one event per beat into the output register.
  stok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_job     (rd_job),
    .status     (qstat),
    .pop        (pop),
    .token_stall(token_stall),
    .token_valid(token_valid),
    .event_res  (event_res),
    .token_kind (token_kind),
    .token_byte (token_byte),
    .run_last   (run_last)
  );

endmodule

// ===== hdl/stok_front.sv =====
// ----------------------------------------------------------------------------
// Script tokenizer front end
// Classifies each accepted byte against the lexer state and builds the list
// of token events it causes, as one job for the queue.
// ----------------------------------------------------------------------------
module stok_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               strict_quotes,
  input  logic               accept,
  input  logic [7:0]         char_byte,
  input  logic               end_of_text,
  output logic               push,
  output stok_pkg::tok_job_t job
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_COMMENT = 3'd1,
    M_STRING  = 3'd2,
    M_NUMBER  = 3'd3,
    M_HELD    = 3'd4,
    M_OPEN    = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic        qp, qp_next;
  logic [1:0]  held, held_next;

  stok_pkg::tok_evt_t [stok_pkg::JOB_EVTS-1:0] evs;
  logic [stok_pkg::JIDX_W:0] n;
  logic                      do_start;
  logic                      closed;
  logic                      sep;

  assign sep = stok_pkg::is_space(char_byte) || stok_pkg::is_op(char_byte);

  always_comb begin
    mode_next = mode;
    qp_next   = qp;
    held_next = held;
    evs       = '0;
    n         = '0;
    do_start  = 1'b0;
    closed    = 1'b0;

    case (mode)
      M_COMMENT: begin
        if (char_byte == stok_pkg::CH_LF) begin
          mode_next = M_IDLE;
        end
      end
      M_STRING: begin
        if (qp) begin
          qp_next = 1'b0;
          if ((char_byte == stok_pkg::CH_SPACE) || (char_byte == stok_pkg::CH_LF)) begin
            evs[n[stok_pkg::JIDX_W-1:0]] =
              stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_QUOTED, 8'h00);
            n = n + 1'b1;
            mode_next = M_IDLE;
            closed = 1'b1;
          end else begin
            evs[n[stok_pkg::JIDX_W-1:0]] =
              stok_pkg::mk_evt(stok_pkg::EV_CHAR, stok_pkg::KIND_QUOTED, stok_pkg::CH_QUOTE);
            n = n + 1'b1;
          end
        end
        if (!closed) begin
          if (char_byte == stok_pkg::CH_QUOTE) begin
            if (!strict_quotes || end_of_text) begin
              evs[n[stok_pkg::JIDX_W-1:0]] =
                stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_QUOTED, 8'h00);
              n = n + 1'b1;
              mode_next = M_IDLE;
            end else begin
              qp_next = 1'b1;
            end
          end else begin
            evs[n[stok_pkg::JIDX_W-1:0]] =
              stok_pkg::mk_evt(stok_pkg::EV_CHAR, stok_pkg::KIND_QUOTED, char_byte);
            n = n + 1'b1;
          end
        end
      end
      M_NUMBER: begin
        if (stok_pkg::is_num(char_byte)) begin
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_CHAR, stok_pkg::KIND_NUMBER, char_byte);
          n = n + 1'b1;
        end else begin
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_NUMBER, 8'h00);
          n = n + 1'b1;
          mode_next = M_IDLE;
          do_start  = 1'b1;
        end
      end
      M_HELD: begin
        if (sep) begin
          // A complete mark is dropped; a partial one is released and closed.
          if (held < stok_pkg::BOM_LEN) begin
            evs[n[stok_pkg::JIDX_W-1:0]] =
              stok_pkg::mk_evt(stok_pkg::EV_START, stok_pkg::KIND_BARE, 8'h00);
            n = n + 1'b1;
            for (int i = 0; i < 3; i++) begin
              if (held > 2'(i)) begin
                evs[n[stok_pkg::JIDX_W-1:0]] = stok_pkg::mk_evt(stok_pkg::EV_CHAR,
                  stok_pkg::KIND_BARE, stok_pkg::bom_byte(2'(i)));
                n = n + 1'b1;
              end
            end
            evs[n[stok_pkg::JIDX_W-1:0]] =
              stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00);
            n = n + 1'b1;
          end
          held_next = 2'd0;
          mode_next = M_IDLE;
          do_start  = 1'b1;
        end else if ((held < stok_pkg::BOM_LEN) && (char_byte == stok_pkg::bom_byte(held))) begin
          held_next = held + 2'd1;
        end else begin
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_START, stok_pkg::KIND_BARE, 8'h00);
          n = n + 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (held > 2'(i)) begin
              evs[n[stok_pkg::JIDX_W-1:0]] = stok_pkg::mk_evt(stok_pkg::EV_CHAR,
                stok_pkg::KIND_BARE, stok_pkg::bom_byte(2'(i)));
              n = n + 1'b1;
            end
          end
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, char_byte);
          n = n + 1'b1;
          held_next = 2'd0;
          mode_next = M_OPEN;
        end
      end
      M_OPEN: begin
        if (sep) begin
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00);
          n = n + 1'b1;
          mode_next = M_IDLE;
          do_start  = 1'b1;
        end else begin
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, char_byte);
          n = n + 1'b1;
        end
      end
      default: begin
        mode_next = M_IDLE;
        do_start  = 1'b1;
      end
    endcase

    // A byte that ended a number, bare text or held mark, or any byte in idle, may open a new one.
    if (do_start && !stok_pkg::is_space(char_byte)) begin
      if (char_byte == stok_pkg::CH_HASH) begin
        mode_next = M_COMMENT;
      end else if (char_byte == stok_pkg::CH_QUOTE) begin
        evs[n[stok_pkg::JIDX_W-1:0]] =
          stok_pkg::mk_evt(stok_pkg::EV_START, stok_pkg::KIND_QUOTED, 8'h00);
        n = n + 1'b1;
        qp_next   = 1'b0;
        mode_next = M_STRING;
      end else if (stok_pkg::is_op(char_byte)) begin
        evs[n[stok_pkg::JIDX_W-1:0]] =
          stok_pkg::mk_evt(stok_pkg::EV_START, stok_pkg::KIND_OPERATOR, 8'h00);
        n = n + 1'b1;
        evs[n[stok_pkg::JIDX_W-1:0]] =
          stok_pkg::mk_evt(stok_pkg::EV_CHAR, stok_pkg::KIND_OPERATOR, char_byte);
        n = n + 1'b1;
        evs[n[stok_pkg::JIDX_W-1:0]] =
          stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_OPERATOR, 8'h00);
        n = n + 1'b1;
      end else if (stok_pkg::is_num(char_byte)) begin
        evs[n[stok_pkg::JIDX_W-1:0]] =
          stok_pkg::mk_evt(stok_pkg::EV_START, stok_pkg::KIND_NUMBER, 8'h00);
        n = n + 1'b1;
        evs[n[stok_pkg::JIDX_W-1:0]] =
          stok_pkg::mk_evt(stok_pkg::EV_CHAR, stok_pkg::KIND_NUMBER, char_byte);
        n = n + 1'b1;
        mode_next = M_NUMBER;
      end else if (char_byte == stok_pkg::bom_byte(2'd0)) begin
        held_next = 2'd1;
        mode_next = M_HELD;
      end else begin
        evs[n[stok_pkg::JIDX_W-1:0]] =
          stok_pkg::mk_evt(stok_pkg::EV_START, stok_pkg::KIND_BARE, 8'h00);
        n = n + 1'b1;
        evs[n[stok_pkg::JIDX_W-1:0]] =
          stok_pkg::mk_evt(stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, char_byte);
        n = n + 1'b1;
        mode_next = M_OPEN;
      end
    end

    // End of text closes whatever token is still open.
    if (end_of_text) begin
      case (mode_next)
        M_STRING: begin
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_QUOTED, 8'h00);
          n = n + 1'b1;
        end
        M_NUMBER: begin
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_NUMBER, 8'h00);
          n = n + 1'b1;
        end
        M_OPEN: begin
          evs[n[stok_pkg::JIDX_W-1:0]] =
            stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00);
          n = n + 1'b1;
        end
        M_HELD: begin
          if (held_next < stok_pkg::BOM_LEN) begin
            evs[n[stok_pkg::JIDX_W-1:0]] =
              stok_pkg::mk_evt(stok_pkg::EV_START, stok_pkg::KIND_BARE, 8'h00);
            n = n + 1'b1;
            for (int i = 0; i < 3; i++) begin
              if (held_next > 2'(i)) begin
                evs[n[stok_pkg::JIDX_W-1:0]] = stok_pkg::mk_evt(stok_pkg::EV_CHAR,
                  stok_pkg::KIND_BARE, stok_pkg::bom_byte(2'(i)));
                n = n + 1'b1;
              end
            end
            evs[n[stok_pkg::JIDX_W-1:0]] =
              stok_pkg::mk_evt(stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00);
            n = n + 1'b1;
          end
        end
        default: begin
        end
      endcase
      mode_next = M_IDLE;
      qp_next   = 1'b0;
      held_next = 2'd0;
    end
  end

  assign push     = accept && (n != '0);
  assign job.evts = evs;
  assign job.last = stok_pkg::JIDX_W'(n - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      qp   <= 1'b0;
      held <= 2'd0;
    end else if (accept) begin
      mode <= mode_next;
      qp   <= qp_next;
      held <= held_next;
    end
  end

endmodule

// ===== hdl/stok_queue.sv =====
// ----------------------------------------------------------------------------
// Script tokenizer job queue
// Short first-in first-out store of event jobs between front and back parts.
// ----------------------------------------------------------------------------
module stok_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  stok_pkg::tok_job_t    wr_job,
  input  logic                  pop,
  output stok_pkg::tok_job_t    rd_job,
  output stok_pkg::q_status_t   status
);

  stok_pkg::tok_job_t          slots [stok_pkg::QDEPTH];
  logic [stok_pkg::QPTR_W-1:0] wr_ptr;
  logic [stok_pkg::QPTR_W-1:0] rd_ptr;
  logic [stok_pkg::QPTR_W:0]   fill;

  assign status.empty = (fill == '0);
  assign status.full  = (fill == (stok_pkg::QPTR_W+1)'(stok_pkg::QDEPTH));
  assign rd_job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/stok_back.sv =====
// ----------------------------------------------------------------------------
// Script tokenizer back end
// Walks the events of the head job one beat at a time into the output
// register, marking the final event of each job.
// ----------------------------------------------------------------------------
module stok_back (
  input  logic                clk,
  input  logic                rst,
  input  stok_pkg::tok_job_t  rd_job,
  input  stok_pkg::q_status_t status,
  output logic                pop,
  input  logic                token_stall,
  output logic                token_valid,
  output logic [1:0]          event_res,
  output logic [1:0]          token_kind,
  output logic [7:0]          token_byte,
  output logic                run_last
);

  logic [stok_pkg::JIDX_W-1:0] idx;
  logic                        load;
  logic                        at_last;
  stok_pkg::tok_evt_t          cur;

  assign load    = !token_valid || !token_stall;
  assign at_last = (idx == rd_job.last);
  assign cur     = rd_job.evts[idx];
  assign pop     = load && !status.empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      idx         <= '0;
    end else if (load) begin
      token_valid <= !status.empty;
      if (!status.empty) begin
        idx <= at_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !status.empty) begin
      event_res  <= cur.ev;
      token_kind <= cur.kind;
      token_byte <= cur.data;
      run_last   <= at_last;
    end
  end

endmodule

// ===== hdl/stok_checker.sv =====
// ----------------------------------------------------------------------------
// Script tokenizer port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module stok_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] char_byte,
  input logic       end_of_text,
  input logic       token_valid,
  input logic       token_stall,
  input logic [1:0] event_res,
  input logic [1:0] token_kind,
  input logic [7:0] token_byte,
  input logic       run_last
);

  // A stalled text beat stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(char_byte) && $stable(end_of_text))
    else $error("stalled text beat changed");

  // A stalled event beat stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(event_res) &&
      $stable(token_kind) && $stable(token_byte) && $stable(run_last))
    else $error("stalled token beat changed");

  // Only character events carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    token_valid && (event_res != stok_pkg::EV_CHAR) |-> token_byte == 8'h00)
    else $error("non-character event carries a byte");

  // The unused event code never appears.
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (event_res == stok_pkg::EV_START) || (event_res == stok_pkg::EV_CHAR) ||
      (event_res == stok_pkg::EV_END))
    else $error("invalid event code");

  // After reset nothing is offered and the input is not stalled.
  a_reset: assert property (@(posedge clk)
    rst |=> !token_valid && !byte_stall)
    else $error("output or stall active after reset");

endmodule

bind script_tokenizer stok_checker u_stok_checker (
  .clk               (clk),
  .rst               (rst),
  .byte_valid        (byte_valid),
  .byte_stall        (byte_stall),
  .char_byte         (char_byte),
  .end_of_text       (end_of_text),
  .token_valid       (token_valid),
  .token_stall       (token_stall),
  .event_res         (event_res),
  .token_kind        (token_kind),
  .token_byte        (token_byte),
  .run_last          (run_last)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Script tokenizer testbench
// Streams text bytes into the lexer and checks every token event that comes
// back against a lexer model kept here. A short table of hand-picked bytes
// comes first; random texts built from tokens, comments, marks and noise
// follow, under both settings of the strong string mode.
// ----------------------------------------------------------------------------
module tb;

  // Random bytes to send after the directed table, split over several phases
  // that each start with a mode write.
  localparam int RANDOM_ITEMS  = 100;
  localparam int RANDOM_PHASES = 4;
  // Cycles to let pass once nothing is expected: a byte that gives no event
  // may still be in flight.
  localparam int SETTLE_CYCLES = 10;
  // The UTF-8 byte order mark, first byte in the top bits.
  localparam logic [23:0] BYTE_MARK = 24'hEFBBBF;

  // One token event as it appears on the output ports.
  typedef struct packed {
    logic [1:0] ev;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } tok_result_t;

  // Lexer states of the model kept in this testbench.
  typedef enum logic [2:0] {
    LX_IDLE, LX_COMMENT, LX_STRING, LX_NUMBER, LX_HELD, LX_OPEN
  } lex_state_t;

  // A row of the directed table either sends a byte or writes the mode
  // register (value in bit 0 of c). Rows with n_typed set carry the events
  // written out by hand; the others are checked against the model.
  typedef enum logic {ROW_BYTE, ROW_CFG} row_type_t;

  typedef struct packed {
    row_type_t         row_type;
    logic [7:0]        c;
    logic              eot;
    logic [1:0]        n_typed;
    tok_result_t [0:2] typed;
  } stim_row_t;

  // How the receiver stalls for a while.
  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG
  } stall_style_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_mode_data = 1'b0;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] char_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       token_valid;
  logic       token_stall = 1'b0;
  logic [1:0] event_res;
  logic [1:0] token_kind;
  logic [7:0] token_byte;
  logic       run_last;

  // Model state: the lexer state, a quote held back in strong mode, the
  // number of leading mark bytes held, and our copy of the mode register.
  lex_state_t  lx_state;
  logic        quote_held;
  logic [1:0]  mark_len;
  logic        strong_mode;

  // Events of the byte being modelled, and all events still owed by the DUT.
  tok_result_t byte_events[$];
  tok_result_t pending_events[$];
  tok_result_t oldest;

  stim_row_t   directed_rows[$];
  logic [7:0]  text_bytes[$];

  int          mismatches = 0;
  int          burst_left = 0;
  int          stall_count = 0;
  stall_style_t stall_style = STALL_NONE;

  script_tokenizer i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .strong_string_mode (cfg_mode_data),
    .byte_valid         (byte_valid),
    .byte_stall         (byte_stall),
    .char_byte          (char_byte),
    .end_of_text        (end_of_text),
    .token_valid        (token_valid),
    .token_stall        (token_stall),
    .event_res          (event_res),
    .token_kind         (token_kind),
    .token_byte         (token_byte),
    .run_last           (run_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $error("timeout with %0d events still expected", pending_events.size());
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Lexer model
  // --------------------------------------------------------------------------

  function automatic logic is_gap(logic [7:0] c);
    return c == stok_pkg::CH_SPACE || c == stok_pkg::CH_TAB || c == stok_pkg::CH_LF;
  endfunction

  function automatic logic is_operator(logic [7:0] c);
    return c == stok_pkg::CH_EQ || c == stok_pkg::CH_LBRACE || c == stok_pkg::CH_RBRACE ||
           c == stok_pkg::CH_GT || c == stok_pkg::CH_LT || c == stok_pkg::CH_COLON;
  endfunction

  function automatic logic is_numeric(logic [7:0] c);
    return (c >= stok_pkg::CH_ZERO && c <= stok_pkg::CH_NINE) ||
           c == stok_pkg::CH_DOT || c == stok_pkg::CH_MINUS;
  endfunction

  function automatic logic [7:0] mark_at(int i);
    return BYTE_MARK[8*(2-i) +: 8];
  endfunction

  function automatic void add_event(logic [1:0] ev, logic [1:0] kind, logic [7:0] data);
    tok_result_t r;
    r.ev   = ev;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    byte_events = {byte_events, r};
  endfunction

  // A byte seen while no token is open.
  function automatic void open_token(logic [7:0] c);
    if (is_gap(c)) begin
      // White space opens nothing.
    end else if (c == stok_pkg::CH_HASH) begin
      lx_state = LX_COMMENT;
    end else if (c == stok_pkg::CH_QUOTE) begin
      add_event(stok_pkg::EV_START, stok_pkg::KIND_QUOTED, 8'h00);
      quote_held = 1'b0;
      lx_state = LX_STRING;
    end else if (is_operator(c)) begin
      add_event(stok_pkg::EV_START, stok_pkg::KIND_OPERATOR, 8'h00);
      add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_OPERATOR, c);
      add_event(stok_pkg::EV_END, stok_pkg::KIND_OPERATOR, 8'h00);
    end else if (is_numeric(c)) begin
      add_event(stok_pkg::EV_START, stok_pkg::KIND_NUMBER, 8'h00);
      add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_NUMBER, c);
      lx_state = LX_NUMBER;
    end else if (c == mark_at(0)) begin
      mark_len = 2'd1;
      lx_state = LX_HELD;
    end else begin
      add_event(stok_pkg::EV_START, stok_pkg::KIND_BARE, 8'h00);
      add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, c);
      lx_state = LX_OPEN;
    end
  endfunction

  // Held mark bytes come out as an ordinary bare-text start and characters.
  function automatic void release_mark();
    add_event(stok_pkg::EV_START, stok_pkg::KIND_BARE, 8'h00);
    for (int i = 0; i < mark_len; i++) begin
      add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, mark_at(i));
    end
    mark_len = 2'd0;
  endfunction

  // A complete mark vanishes; a partial one is released and closed.
  function automatic void close_mark();
    if (mark_len == 2'd3) begin
      mark_len = 2'd0;
    end else begin
      release_mark();
      add_event(stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic eot);
    byte_events.delete();
    case (lx_state)
      LX_COMMENT: begin
        if (c == stok_pkg::CH_LF) begin
          lx_state = LX_IDLE;
        end
      end
      LX_STRING: begin
        if (quote_held && (c == stok_pkg::CH_SPACE || c == stok_pkg::CH_LF)) begin
          quote_held = 1'b0;
          add_event(stok_pkg::EV_END, stok_pkg::KIND_QUOTED, 8'h00);
          lx_state = LX_IDLE;
        end else begin
          if (quote_held) begin
            quote_held = 1'b0;
            add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_QUOTED, stok_pkg::CH_QUOTE);
          end
          if (c != stok_pkg::CH_QUOTE) begin
            add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_QUOTED, c);
          end else if (!strong_mode || eot) begin
            add_event(stok_pkg::EV_END, stok_pkg::KIND_QUOTED, 8'h00);
            lx_state = LX_IDLE;
          end else begin
            quote_held = 1'b1;
          end
        end
      end
      LX_NUMBER: begin
        if (is_numeric(c)) begin
          add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_NUMBER, c);
        end else begin
          add_event(stok_pkg::EV_END, stok_pkg::KIND_NUMBER, 8'h00);
          lx_state = LX_IDLE;
          open_token(c);
        end
      end
      LX_HELD: begin
        if (is_gap(c) || is_operator(c)) begin
          close_mark();
          lx_state = LX_IDLE;
          open_token(c);
        end else if (mark_len < 2'd3 && c == mark_at(mark_len)) begin
          mark_len = mark_len + 2'd1;
        end else begin
          release_mark();
          add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, c);
          lx_state = LX_OPEN;
        end
      end
      LX_OPEN: begin
        if (is_gap(c) || is_operator(c)) begin
          add_event(stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00);
          lx_state = LX_IDLE;
          open_token(c);
        end else begin
          add_event(stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, c);
        end
      end
      default: begin
        lx_state = LX_IDLE;
        open_token(c);
      end
    endcase

    if (eot) begin
      case (lx_state)
        LX_STRING: add_event(stok_pkg::EV_END, stok_pkg::KIND_QUOTED, 8'h00);
        LX_NUMBER: add_event(stok_pkg::EV_END, stok_pkg::KIND_NUMBER, 8'h00);
        LX_OPEN:   add_event(stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00);
        LX_HELD:   close_mark();
        default: begin
        end
      endcase
      lx_state   = LX_IDLE;
      quote_held = 1'b0;
      mark_len   = 2'd0;
    end

    if (byte_events.size() > 0) begin
      byte_events[byte_events.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void commit_events();
    foreach (byte_events[k]) begin
      pending_events = {pending_events, byte_events[k]};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one byte, holds it until the beat is taken, then runs the model.
  task automatic send_byte(input logic [7:0] c, input logic eot);
    byte_valid  <= 1'b1;
    char_byte   <= c;
    end_of_text <= eot;
    do begin
      @(posedge clk);
    end while (byte_stall);
    lex_byte(c, eot);
  endtask

  // Bursts of back-to-back beats with gaps of random length between them.
  // Now and then a long burst gives a stretch with no idling at all.
  task automatic pace_sender();
    int unsigned hold;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 12);
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      byte_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
  endtask

  // Stops sending until every expected event has come out, then lets the
  // pipeline settle in case the last byte gave no event at all.
  task automatic drain_events();
    byte_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_mode(input logic value);
    cfg_valid     <= 1'b1;
    cfg_mode_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid   <= 1'b0;
    strong_mode = value;
  endtask

  function automatic void put_byte(logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  function automatic void add_row(stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic logic [7:0] pick_gap();
    case ($urandom_range(0, 2))
      0:       return stok_pkg::CH_SPACE;
      1:       return stok_pkg::CH_TAB;
      default: return stok_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Builds one text from a random mix of tokens. Most pieces are well formed
  // so that every lexer state is reached; noise bytes cover the rest of the
  // byte range.
  function automatic void build_text();
    int unsigned pieces;
    int unsigned len;
    int unsigned r;
    text_bytes.delete();
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1: put_byte(pick_gap());
        2: begin
          case ($urandom_range(0, 5))
            0:       put_byte(stok_pkg::CH_EQ);
            1:       put_byte(stok_pkg::CH_LBRACE);
            2:       put_byte(stok_pkg::CH_RBRACE);
            3:       put_byte(stok_pkg::CH_GT);
            4:       put_byte(stok_pkg::CH_LT);
            default: put_byte(stok_pkg::CH_COLON);
          endcase
        end
        3: begin
          len = $urandom_range(1, 4);
          repeat (len) begin
            r = $urandom_range(0, 11);
            if (r < 10) begin
              put_byte(stok_pkg::CH_ZERO + 8'(r));
            end else begin
              put_byte(r == 10 ? stok_pkg::CH_DOT : stok_pkg::CH_MINUS);
            end
          end
        end
        4: begin
          len = $urandom_range(1, 4);
          repeat (len) begin
            put_byte($urandom_range(0, 3) == 0 ?
                     8'($urandom_range(8'h80, 8'hFE)) : pick_letter());
          end
        end
        5: begin
          // Quoted string, with the odd quote or space inside it.
          put_byte(stok_pkg::CH_QUOTE);
          len = $urandom_range(0, 4);
          repeat (len) begin
            r = $urandom_range(0, 5);
            if (r == 0) begin
              put_byte(stok_pkg::CH_QUOTE);
            end else if (r == 1) begin
              put_byte(stok_pkg::CH_SPACE);
            end else begin
              put_byte(pick_letter());
            end
          end
          put_byte(stok_pkg::CH_QUOTE);
        end
        6: begin
          put_byte(stok_pkg::CH_HASH);
          len = $urandom_range(0, 3);
          repeat (len) put_byte(8'($urandom_range(0, 255)));
          put_byte(stok_pkg::CH_LF);
        end
        7: begin
          // Full byte order mark, sometimes with text after it, or a prefix
          // that breaks off.
          put_byte(mark_at(0));
          case ($urandom_range(0, 2))
            0: begin
              put_byte(mark_at(1));
              put_byte(mark_at(2));
              if ($urandom_range(0, 2) == 0) begin
                put_byte(pick_letter());
              end
            end
            1: begin
              put_byte(mark_at(1));
              put_byte(pick_letter());
            end
            default: put_byte(8'($urandom_range(0, 255)));
          endcase
        end
        default: begin
          len = $urandom_range(1, 2);
          repeat (len) put_byte(8'($urandom_range(0, 255)));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        put_byte(pick_gap());
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------

  // The receiver switches between stall styles at random: no stall, light and
  // heavy random stalls, and long stalls with one open cycle in eight. Gaps
  // thereby land on every stage of the event stream.
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      stall_count <= $urandom_range(16, 80);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_style)
      STALL_NONE:  token_stall <= 1'b0;
      STALL_LIGHT: token_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: token_stall <= ($urandom_range(0, 1) == 0);
      default:     token_stall <= (stall_count % 8 != 0);
    endcase
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Every beat on the event channel is matched with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) begin
      if (pending_events.size() == 0) begin
        $error("event with none expected: event_res %0d token_kind %0d token_byte %0d",
               event_res, token_kind, token_byte);
        mismatches++;
      end else begin
        oldest = pending_events.pop_front();
        check_field("event_res", oldest.ev, event_res);
        check_field("token_kind", oldest.kind, token_kind);
        check_field("token_byte", oldest.data, token_byte);
        check_field("run_last", oldest.last, run_last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------

  // Bytes picked to reach each corner of the lexer: an operator and the two
  // extreme byte values with the end flag set, a comment, a number ended by
  // an operator, a full mark dropped before a tab, a broken mark, a mark
  // prefix cut off by the end of text, an empty string, then strong mode
  // with held quotes, a quote held across a mode change, and a quote at the
  // very end of the text.
  function automatic void fill_directed();
    add_row('{ROW_BYTE, stok_pkg::CH_EQ, 1'b0, 2'd3, '{
      '{stok_pkg::EV_START, stok_pkg::KIND_OPERATOR, 8'h00, 1'b0},
      '{stok_pkg::EV_CHAR, stok_pkg::KIND_OPERATOR, stok_pkg::CH_EQ, 1'b0},
      '{stok_pkg::EV_END, stok_pkg::KIND_OPERATOR, 8'h00, 1'b1}}});
    add_row('{ROW_BYTE, 8'h00, 1'b1, 2'd3, '{
      '{stok_pkg::EV_START, stok_pkg::KIND_BARE, 8'h00, 1'b0},
      '{stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, 8'h00, 1'b0},
      '{stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00, 1'b1}}});
    add_row('{ROW_BYTE, 8'hFF, 1'b1, 2'd3, '{
      '{stok_pkg::EV_START, stok_pkg::KIND_BARE, 8'h00, 1'b0},
      '{stok_pkg::EV_CHAR, stok_pkg::KIND_BARE, 8'hFF, 1'b0},
      '{stok_pkg::EV_END, stok_pkg::KIND_BARE, 8'h00, 1'b1}}});
    add_row('{ROW_BYTE, stok_pkg::CH_HASH, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, 8'h7A, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_LF, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_MINUS, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_NINE, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_LT, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, 8'hEF, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, 8'hBB, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, 8'hBF, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_TAB, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, 8'hEF, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, 8'h71, 1'b1, 2'd0, '0});
    add_row('{ROW_BYTE, 8'hEF, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, 8'hBB, 1'b1, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_QUOTE, 1'b0, 2'd1, '{
      '{stok_pkg::EV_START, stok_pkg::KIND_QUOTED, 8'h00, 1'b1}, '0, '0}});
    add_row('{ROW_BYTE, stok_pkg::CH_QUOTE, 1'b0, 2'd0, '0});
    add_row('{ROW_CFG, 8'h01, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_QUOTE, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_QUOTE, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, 8'h62, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_QUOTE, 1'b0, 2'd0, '0});
    add_row('{ROW_CFG, 8'h00, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_SPACE, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_QUOTE, 1'b0, 2'd0, '0});
    add_row('{ROW_CFG, 8'h01, 1'b0, 2'd0, '0});
    add_row('{ROW_BYTE, stok_pkg::CH_QUOTE, 1'b1, 2'd0, '0});
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int random_sent;
    random_sent = 0;
    lx_state    = LX_IDLE;
    quote_held  = 1'b0;
    mark_len    = 2'd0;
    strong_mode = 1'b0;
    fill_directed();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Typed rows stand in for the model's events on that byte;
    // the model still runs so that its state follows the text.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].row_type == ROW_CFG) begin
        drain_events();
        write_mode(directed_rows[r].c[0]);
      end else begin
        send_byte(directed_rows[r].c, directed_rows[r].eot);
        if (directed_rows[r].n_typed != 2'd0) begin
          for (int k = 0; k < directed_rows[r].n_typed; k++) begin
            pending_events = {pending_events, directed_rows[r].typed[k]};
          end
        end else begin
          commit_events();
        end
        pace_sender();
      end
    end

    // Random part: each phase waits for the block to empty, sets the mode,
    // then sends whole texts. Draining before each write also makes the
    // sender pause until every expected event has come out.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_events();
      write_mode(phase % 2 != 0);
      while (random_sent < (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
        build_text();
        foreach (text_bytes[i]) begin
          send_byte(text_bytes[i], i == text_bytes.size() - 1);
          commit_events();
          pace_sender();
          random_sent++;
        end
      end
    end

    drain_events();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stok_pkg.sv
hdl/stok_front.sv
hdl/stok_queue.sv
hdl/stok_back.sv
hdl/script_tokenizer.sv
hdl/stok_checker.sv
test/tb.sv
